// ===== hw/rtl/nmsf_pkg.sv =====
// Package for the neighbour mean smoothing filter.
// Holds shared sizes and the job descriptor type; no dependencies.
`default_nettype none
package nmsf_pkg;
    localparam int MAX_SIZE_DEF = 32;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_BITS = 6;
    localparam int POS_BITS = 5;
    localparam logic [CFG_BITS-1:0] SIZE_RESET = 6'd16;

    // One output job: the position to smooth and whether it ends the frame.
    typedef struct packed {
        logic [POS_BITS-1:0] row;
        logic [POS_BITS-1:0] col;
        logic [POS_BITS:0]   size;
        logic                last;
    } t_job;
endpackage
`default_nettype wire

// ===== hw/rtl/nmsf_front.sv =====
// Front end of the neighbour mean smoothing filter: counts input positions and
// turns the inputs into output jobs. Depends on nmsf_pkg.
`default_nettype none
module nmsf_front #(
    parameter int MAX_SIZE = nmsf_pkg::MAX_SIZE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [nmsf_pkg::CFG_BITS-1:0] i_cfg_data,
    input  wire logic                          i_push,
    output logic                               o_full,
    output logic                               o_wr_en,
    output logic [nmsf_pkg::POS_BITS-1:0]      o_wr_row,
    output logic [nmsf_pkg::POS_BITS-1:0]      o_wr_col,
    output logic                               o_job_valid,
    output nmsf_pkg::t_job                     o_job,
    input  wire logic                          i_job_full,
    input  wire logic                          i_back_busy
);
    localparam int PB = nmsf_pkg::POS_BITS;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EDGE  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state                       r_state, n_state;
    logic [nmsf_pkg::CFG_BITS-1:0] r_size_cfg;
    logic [PB-1:0]                r_row, n_row, r_col, n_col;
    logic [PB-1:0]                r_jrow, n_jrow, r_jcol, n_jcol;
    logic [PB:0]                  w_n;
    logic [PB-1:0]                w_nm1, w_r, w_c;
    logic                         w_acc;

    always_comb begin
        if (r_size_cfg < 6'd2) begin
            w_n = (PB+1)'(2);
        end else if (r_size_cfg > 6'(MAX_SIZE)) begin
            w_n = (PB+1)'(MAX_SIZE);
        end else begin
            w_n = r_size_cfg[PB:0];
        end
    end
    assign w_nm1 = PB'(w_n - 1'b1);
    assign w_r = ({1'b0, r_row} >= w_n || {1'b0, r_col} >= w_n) ? '0 : r_row;
    assign w_c = ({1'b0, r_row} >= w_n || {1'b0, r_col} >= w_n) ? '0 : r_col;

    assign o_full = (r_state != S_IDLE) || i_job_full || i_back_busy;
    assign w_acc = i_push && !o_full;
    assign o_wr_en = w_acc;
    assign o_wr_row = w_r;
    assign o_wr_col = w_c;

    always_comb begin
        n_state = r_state;
        n_row = r_row;
        n_col = r_col;
        n_jrow = r_jrow;
        n_jcol = r_jcol;
        o_job_valid = 1'b0;
        o_job = '{row: r_jrow, col: r_jcol, size: w_n, last: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (w_c == w_nm1) begin
                        n_col = '0;
                        n_row = (w_r == w_nm1) ? '0 : w_r + 1'b1;
                    end else begin
                        n_col = w_c + 1'b1;
                        n_row = w_r;
                    end
                    if (w_r != '0) begin
                        o_job = '{row: w_r - 1'b1, col: w_c - 1'b1, size: w_n,
                                  last: 1'b0};
                        o_job_valid = (w_c != '0);
                        if (w_c == w_nm1) begin
                            n_state = S_EDGE;
                            n_jrow = w_r - 1'b1;
                            n_jcol = w_c;
                        end
                    end
                end
            end
            S_EDGE: begin
                o_job_valid = 1'b1;
                if (!i_job_full) begin
                    if (r_jrow + 1'b1 == w_nm1) begin
                        n_state = S_FLUSH;
                        n_jrow = w_nm1;
                        n_jcol = '0;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FLUSH: begin
                o_job_valid = 1'b1;
                o_job.last = (r_jcol == w_nm1);
                if (!i_job_full) begin
                    n_jcol = r_jcol + 1'b1;
                    if (r_jcol == w_nm1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cfg_we) begin
            n_row = '0;
            n_col = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row <= '0;
            r_col <= '0;
            r_size_cfg <= nmsf_pkg::SIZE_RESET;
        end else begin
            r_state <= n_state;
            r_row <= n_row;
            r_col <= n_col;
            if (i_cfg_we) begin
                r_size_cfg <= i_cfg_data;
            end
        end
        r_jrow <= n_jrow;
        r_jcol <= n_jcol;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_full)
        else $error("front took input while emitting jobs");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid |-> ({1'b0, o_job.row} < o_job.size))
        else $error("job row outside frame");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_job_valid && o_job.last) |-> (r_state == S_FLUSH))
        else $error("frame end marked outside flush");
endmodule
`default_nettype wire

// ===== hw/rtl/nmsf_queue.sv =====
// Short job queue between front and back of the smoothing filter.
// Depends on nmsf_pkg.
`default_nettype none
module nmsf_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr,
    input  wire nmsf_pkg::t_job i_data,
    output logic                o_full,
    input  wire logic           i_rd,
    output logic                o_empty,
    output nmsf_pkg::t_job      o_data
);
    nmsf_pkg::t_job r_mem [4];
    logic [1:0]     r_wp, r_rp;
    logic [2:0]     r_cnt;

    assign o_full = (r_cnt >= 3'd3);
    assign o_empty = (r_cnt == '0);
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_rd && !o_empty) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + 3'(i_wr) - 3'(i_rd && !o_empty);
        end
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 3'd4)
        else $error("job queue overflow");
endmodule
`default_nettype wire

// ===== hw/rtl/nmsf_back.sv =====
// Back end of the smoothing filter: line store, neighbour sum over eight reads,
// truncating divide and a one-entry result register. Depends on nmsf_pkg.
`default_nettype none
module nmsf_back #(
    parameter int MAX_SIZE    = nmsf_pkg::MAX_SIZE_DEF,
    parameter int SAMPLE_BITS = nmsf_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr_en,
    input  wire logic [nmsf_pkg::POS_BITS-1:0] i_wr_row,
    input  wire logic [nmsf_pkg::POS_BITS-1:0] i_wr_col,
    input  wire logic signed [SAMPLE_BITS-1:0] i_wr_data,
    input  wire logic                          i_job_empty,
    input  wire nmsf_pkg::t_job                i_job,
    output logic                               o_job_rd,
    output logic                               o_busy,
    output logic                               o_empty,
    input  wire logic                          i_pop,
    output logic signed [SAMPLE_BITS-1:0]      o_value,
    output logic [nmsf_pkg::POS_BITS-1:0]      o_row,
    output logic [nmsf_pkg::POS_BITS-1:0]      o_col,
    output logic                               o_last
);
    localparam int PB = nmsf_pkg::POS_BITS;
    localparam int CB = $clog2(MAX_SIZE);
    localparam int DEPTH = 3 * MAX_SIZE;
    localparam int AB = $clog2(DEPTH);
    localparam int SB = SAMPLE_BITS + 4;
    localparam int QB = SB + 1;
    localparam int KB = SB + 2;
    localparam logic [63:0] SCALE = 64'd1 << KB;
    localparam logic [KB-1:0] RECIP3 = KB'((SCALE + 64'd2) / 64'd3);
    localparam logic [KB-1:0] RECIP5 = KB'((SCALE + 64'd4) / 64'd5);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_ACC  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    logic signed [SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_rd;
    t_state                        r_state;
    nmsf_pkg::t_job                r_job;
    logic [3:0]                    r_k, r_cnt;
    logic                          r_tvalid;
    logic signed [SB-1:0]          r_sum;
    logic [QB-1:0]                 r_quo;
    logic                          r_neg;
    logic signed [SAMPLE_BITS-1:0] r_value;
    logic [PB-1:0]                 r_orow, r_ocol;
    logic                          r_olast, r_full;

    logic [1:0]    w_dr, w_dc;
    logic [PB:0]   w_kr, w_kc;
    logic          w_in;
    logic [1:0]    w_slot, w_wslot;
    logic [AB-1:0] w_raddr, w_waddr;
    logic [SB-2:0] w_abs;
    logic [2*SB:0] w_prod3, w_prod5;

    // Row index modulo three by compare and subtract.
    function automatic logic [1:0] slot_of(input logic [PB:0] v);
        logic [PB:0] x;
        x = v;
        if (x >= (PB+1)'(48)) x = x - (PB+1)'(48);
        if (x >= (PB+1)'(24)) x = x - (PB+1)'(24);
        if (x >= (PB+1)'(12)) x = x - (PB+1)'(12);
        if (x >= (PB+1)'(6)) x = x - (PB+1)'(6);
        if (x >= (PB+1)'(3)) x = x - (PB+1)'(3);
        return x[1:0];
    endfunction

    always_comb begin
        unique case (r_k)
            4'd0: begin w_dr = 2'd0; w_dc = 2'd0; end
            4'd1: begin w_dr = 2'd0; w_dc = 2'd1; end
            4'd2: begin w_dr = 2'd0; w_dc = 2'd2; end
            4'd3: begin w_dr = 2'd1; w_dc = 2'd0; end
            4'd4: begin w_dr = 2'd1; w_dc = 2'd2; end
            4'd5: begin w_dr = 2'd2; w_dc = 2'd0; end
            4'd6: begin w_dr = 2'd2; w_dc = 2'd1; end
            default: begin w_dr = 2'd2; w_dc = 2'd2; end
        endcase
    end
    assign w_kr = {1'b0, r_job.row} + (PB+1)'(w_dr) - 1'b1;
    assign w_kc = {1'b0, r_job.col} + (PB+1)'(w_dc) - 1'b1;
    assign w_in = (w_kr < r_job.size) && (w_kc < r_job.size);
    assign w_slot = slot_of(w_kr);
    assign w_wslot = slot_of({1'b0, i_wr_row});
    assign w_raddr = AB'(w_slot * MAX_SIZE + w_kc[CB-1:0]);
    assign w_waddr = AB'(w_wslot * MAX_SIZE + i_wr_col[CB-1:0]);

    // The divisor is 3, 5 or 8; the first two use a reciprocal multiplication.
    assign w_abs = r_sum[SB-2:0];
    assign w_prod3 = (2*SB+1)'(w_abs) * (2*SB+1)'(RECIP3);
    assign w_prod5 = (2*SB+1)'(w_abs) * (2*SB+1)'(RECIP5);

    assign o_job_rd = (r_state == S_IDLE) && !i_job_empty;
    assign o_busy = (r_state == S_READ);
    assign o_empty = !r_full;
    assign o_value = r_value;
    assign o_row = r_orow;
    assign o_col = r_ocol;
    assign o_last = r_olast;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[w_waddr] <= i_wr_data;
        end
        r_rd <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_full <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && (!r_full || i_pop)) begin
                r_full <= 1'b1;
            end else if (i_pop && r_full) begin
                r_full <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_job_empty) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (r_k == 4'd8) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: r_state <= S_DIV;
                S_DIV: r_state <= S_OUT;
                S_OUT: begin
                    if (!r_full || i_pop) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_job <= i_job;
                r_k <= '0;
                r_cnt <= '0;
                r_sum <= '0;
                r_tvalid <= 1'b0;
            end
            S_READ: begin
                if (r_tvalid) begin
                    r_sum <= r_sum + SB'(r_rd);
                    r_cnt <= r_cnt + 1'b1;
                end
                r_tvalid <= w_in && (r_k != 4'd8);
                r_k <= r_k + 1'b1;
            end
            S_ACC: begin
                if (r_tvalid) begin
                    r_neg <= (r_sum + SB'(r_rd)) < 0;
                    r_sum <= ((r_sum + SB'(r_rd)) < 0) ? -(r_sum + SB'(r_rd))
                                                       : r_sum + SB'(r_rd);
                    r_cnt <= r_cnt + 1'b1;
                end else begin
                    r_neg <= r_sum < 0;
                    r_sum <= (r_sum < 0) ? -r_sum : r_sum;
                end
            end
            S_DIV: begin
                case (r_cnt)
                    4'd3: r_quo <= QB'(w_prod3 >> KB);
                    4'd5: r_quo <= QB'(w_prod5 >> KB);
                    default: r_quo <= QB'(w_abs >> 3);
                endcase
            end
            S_OUT: begin
                if (!r_full || i_pop) begin
                    r_value <= r_neg ? SAMPLE_BITS'(-r_quo) : SAMPLE_BITS'(r_quo);
                    r_orow <= r_job.row;
                    r_ocol <= r_job.col;
                    r_olast <= r_job.last;
                end
            end
            default: r_k <= '0;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt == 4'd3 || r_cnt == 4'd5 || r_cnt == 4'd8))
        else $error("unexpected neighbour count");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_rd |=> (r_state == S_READ))
        else $error("job taken without starting");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && !i_pop) |=> ($stable(r_value) && r_full))
        else $error("held result changed");
endmodule
`default_nettype wire

// ===== hw/rtl/neighbour_mean_smoothing_filter.sv =====
// Top level of the neighbour mean smoothing filter.
// Instantiates nmsf_front, nmsf_queue and nmsf_back; depends on nmsf_pkg.
//
// Takes an N x N frame in raster order and returns, per position, the mean of
// its in-frame eight neighbours, truncated toward zero. A row's results follow
// once the row below arrives; the last input flushes the rest, marking the
// final result with o_frame_last. In the back end each result passes through
// S_IDLE to take the job, S_READ for the eight reads of the line store, S_ACC to
// finish the sum, S_DIV for the reciprocal or shift divide and S_OUT to load the
// result register. An input is taken only after every earlier job has read its
// neighbours, so an input that causes a result holds the next one until those
// reads are done, and one that causes none lets the next be taken in the cycle
// after. A row end adds one job and the last input of a frame adds N+1, and any
// result left waiting on pop stalls the back end. Writing the frame size restarts
// the frame.
`default_nettype none
module neighbour_mean_smoothing_filter #(
    parameter int MAX_SIZE    = nmsf_pkg::MAX_SIZE_DEF,
    parameter int SAMPLE_BITS = nmsf_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [nmsf_pkg::CFG_BITS-1:0] i_cfg_data,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic signed [SAMPLE_BITS-1:0] i_pixel_value,
    output logic                               empty,
    input  wire logic                          pop,
    output logic signed [SAMPLE_BITS-1:0]      o_smoothed_value,
    output logic [nmsf_pkg::POS_BITS-1:0]      o_out_row,
    output logic [nmsf_pkg::POS_BITS-1:0]      o_out_col,
    output logic                               o_frame_last
);
    logic                            w_wr_en, w_job_valid, w_qfull, w_qempty, w_jrd;
    logic                            w_reading;
    logic [nmsf_pkg::POS_BITS-1:0]   w_wr_row, w_wr_col;
    nmsf_pkg::t_job                  w_job, w_qjob;

    nmsf_front #(.MAX_SIZE(MAX_SIZE)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_push(push), .o_full(full), .o_wr_en(w_wr_en), .o_wr_row(w_wr_row),
        .o_wr_col(w_wr_col), .o_job_valid(w_job_valid), .o_job(w_job),
        .i_job_full(w_qfull), .i_back_busy(!w_qempty || w_reading)
    );

    nmsf_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(w_job_valid && !w_qfull),
        .i_data(w_job), .o_full(w_qfull), .i_rd(w_jrd), .o_empty(w_qempty),
        .o_data(w_qjob)
    );

    nmsf_back #(.MAX_SIZE(MAX_SIZE), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr_en(w_wr_en), .i_wr_row(w_wr_row),
        .i_wr_col(w_wr_col), .i_wr_data(i_pixel_value), .i_job_empty(w_qempty),
        .i_job(w_qjob), .o_job_rd(w_jrd), .o_busy(w_reading), .o_empty(empty),
        .i_pop(pop), .o_value(o_smoothed_value), .o_row(o_out_row),
        .o_col(o_out_col), .o_last(o_frame_last)
    );
endmodule
`default_nettype wire

// ===== tb/neighbour_mean_smoothing_filter_test.sv =====
// Testbench for the neighbour mean smoothing filter, checked against a built-in predictor.
// Depends on nmsf_pkg and the neighbour_mean_smoothing_filter top level.
`timescale 1ns / 1ps
module neighbour_mean_smoothing_filter_test;
    localparam int OP_PIXEL = 0;
    localparam int OP_SIZE  = 1;
    localparam int OP_DRAIN = 2;
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        int          op;
        logic [15:0] data;
    } t_stim;

    typedef struct {
        logic signed [15:0] value;
        logic [4:0]         row;
        logic [4:0]         col;
        logic               last;
    } t_smooth;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [nmsf_pkg::CFG_BITS-1:0] i_cfg_data;
    logic push;
    logic full;
    logic signed [15:0] i_pixel_value;
    logic empty;
    logic pop;
    logic signed [15:0] o_smoothed_value;
    logic [4:0] o_out_row;
    logic [4:0] o_out_col;
    logic o_frame_last;

    t_stim   stim_q[$];
    t_smooth smooth_q[$];
    logic signed [15:0] line_rows[0:3*32-1];
    int row_pos;
    int col_pos;
    logic [5:0] size_reg;
    int errors;
    int pixels_sent;
    int results_seen;
    int size_writes;
    int quiet_cycles;
    int cycle_count;
    int hold_cycles;
    bit hold_done;

    neighbour_mean_smoothing_filter u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .push(push),
        .full(full),
        .i_pixel_value(i_pixel_value),
        .empty(empty),
        .pop(pop),
        .o_smoothed_value(o_smoothed_value),
        .o_out_row(o_out_row),
        .o_out_col(o_out_col),
        .o_frame_last(o_frame_last)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic int side_length();
        int n;
        n = size_reg;
        if (n < 2) n = 2;
        if (n > 32) n = 32;
        return n;
    endfunction

    function automatic logic signed [15:0] neighbour_mean(int r, int c, int n);
        int sum;
        int cnt;
        int k;
        int l;
        sum = 0;
        cnt = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                k = r + dr;
                l = c + dc;
                if (!(dr == 0 && dc == 0) && k >= 0 && l >= 0 && k < n && l < n) begin
                    sum += line_rows[(k % 3) * 32 + l];
                    cnt++;
                end
            end
        end
        sum = sum / cnt;
        return sum[15:0];
    endfunction

    function automatic void add_smoothed(int r, int c, int n, bit last);
        t_smooth s;
        s.value = neighbour_mean(r, c, n);
        s.row = r[4:0];
        s.col = c[4:0];
        s.last = last;
        smooth_q.push_back(s);
    endfunction

    function automatic void take_pixel(logic signed [15:0] px);
        int n;
        int r;
        int c;
        n = side_length();
        r = row_pos;
        c = col_pos;
        if (r >= n || c >= n) begin
            r = 0;
            c = 0;
        end
        line_rows[(r % 3) * 32 + c] = px;
        if (r >= 1) begin
            if (c >= 1) add_smoothed(r - 1, c - 1, n, 1'b0);
            if (c == n - 1) begin
                add_smoothed(r - 1, c, n, 1'b0);
                if (r == n - 1) begin
                    for (int j = 0; j < n; j++) add_smoothed(r, j, n, j == n - 1);
                end
            end
        end
        if (c == n - 1) begin
            col_pos = 0;
            row_pos = (r == n - 1) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endfunction

    function automatic int idle_percent(bit sender);
        if (pixels_sent < 90) return sender ? 17 : 61;
        if (pixels_sent < 180) return sender ? 61 : 17;
        return 0;
    endfunction

    function automatic void add_op(int op, logic [15:0] data);
        t_stim s;
        s.op = op;
        s.data = data;
        stim_q.push_back(s);
    endfunction

    function automatic logic [15:0] random_pixel();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            default: return 16'($urandom());
        endcase
    endfunction

    always @(posedge i_clk) begin
        logic nxt_push;
        logic nxt_we;
        logic [15:0] nxt_px;
        logic [5:0] nxt_cfg;
        nxt_push = 1'b0;
        nxt_we = 1'b0;
        nxt_px = i_pixel_value;
        nxt_cfg = i_cfg_data;
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (push && !full) begin
                take_pixel(i_pixel_value);
                pixels_sent++;
            end else if (push) begin
                nxt_push = 1'b1;
            end
            if (smooth_q.size() == 0 && !push && !i_cfg_we) quiet_cycles <= quiet_cycles + 1;
            else quiet_cycles <= 0;
            if (!nxt_push && !i_cfg_we && stim_q.size() > 0) begin
                case (stim_q[0].op)
                    OP_PIXEL: begin
                        if ($urandom_range(0, 99) >= idle_percent(1'b1)) begin
                            nxt_px = stim_q[0].data;
                            nxt_push = 1'b1;
                            void'(stim_q.pop_front());
                        end
                    end
                    OP_SIZE: begin
                        if (!push && quiet_cycles >= SETTLE_CYCLES) begin
                            nxt_cfg = stim_q[0].data[5:0];
                            nxt_we = 1'b1;
                            size_reg = nxt_cfg;
                            row_pos = 0;
                            col_pos = 0;
                            size_writes++;
                            void'(stim_q.pop_front());
                        end
                    end
                    default: begin
                        if (!push && smooth_q.size() == 0) void'(stim_q.pop_front());
                    end
                endcase
            end
        end
        push <= nxt_push;
        i_cfg_we <= nxt_we;
        i_pixel_value <= nxt_px;
        i_cfg_data <= nxt_cfg;
    end

    always @(posedge i_clk) begin
        t_smooth s;
        logic nxt_pop;
        nxt_pop = 1'b0;
        if (i_rst_n) begin
            if (pop && !empty) begin
                results_seen++;
                if (smooth_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transfer row %0d col %0d value %0d", $time,
                             o_out_row, o_out_col, o_smoothed_value);
                end else begin
                    s = smooth_q.pop_front();
                    if (o_smoothed_value !== s.value || o_out_row !== s.row
                        || o_out_col !== s.col || o_frame_last !== s.last) begin
                        errors++;
                        $display("%0t: expected value %0d row %0d col %0d last %0b, got %0d %0d %0d %0b",
                                 $time, s.value, s.row, s.col, s.last, o_smoothed_value,
                                 o_out_row, o_out_col, o_frame_last);
                    end
                end
            end
            if (!hold_done && results_seen >= 30) begin
                hold_done = 1'b1;
                hold_cycles = 1500;
            end
            if (hold_cycles > 0) hold_cycles--;
            else nxt_pop = $urandom_range(0, 99) >= idle_percent(1'b0);
        end
        pop <= nxt_pop;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int n;
        int cnt;
        push = 1'b0;
        pop = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_pixel_value = '0;
        i_rst_n = 1'b0;
        errors = 0;
        pixels_sent = 0;
        results_seen = 0;
        size_writes = 0;
        cycle_count = 0;
        hold_cycles = 0;
        hold_done = 1'b0;
        row_pos = 0;
        col_pos = 0;
        size_reg = nmsf_pkg::SIZE_RESET;
        for (int i = 0; i < 96; i++) line_rows[i] = '0;

        add_op(OP_SIZE, 16'd2);
        add_op(OP_PIXEL, 16'h7fff);
        add_op(OP_PIXEL, 16'h8000);
        add_op(OP_PIXEL, 16'hffff);
        add_op(OP_PIXEL, 16'h0000);
        add_op(OP_SIZE, 16'd0);
        for (int i = 0; i < 4; i++) add_op(OP_PIXEL, 16'h8000);
        add_op(OP_SIZE, 16'd1);
        for (int i = 0; i < 4; i++) add_op(OP_PIXEL, 16'h7fff);
        add_op(OP_SIZE, 16'd3);
        for (int i = 0; i < 5; i++) add_op(OP_PIXEL, 16'(16'h1234 + i));
        add_op(OP_SIZE, 16'd4);
        for (int i = 0; i < 16; i++) add_op(OP_PIXEL, i[0] ? 16'haaaa : 16'h5555);
        add_op(OP_DRAIN, 16'd0);

        while (stim_q.size() < 270) begin
            case ($urandom_range(0, 9))
                0: begin
                    add_op(OP_SIZE, $urandom_range(0, 1) ? 16'd63 : 16'd32);
                    cnt = $urandom_range(34, 70);
                end
                1: begin
                    add_op(OP_SIZE, 16'($urandom_range(2, 7)));
                    cnt = $urandom_range(1, 20);
                end
                default: begin
                    n = $urandom_range(2, 6);
                    add_op(OP_SIZE, 16'(n));
                    cnt = n * n * $urandom_range(1, 2);
                end
            endcase
            for (int i = 0; i < cnt; i++) add_op(OP_PIXEL, random_pixel());
            if ($urandom_range(0, 4) == 0) add_op(OP_DRAIN, 16'd0);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_q.size() == 0 && !push && smooth_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d pixels over %0d frame size writes, checked %0d smoothed samples.",
                 pixels_sent, size_writes, results_seen);
        if (errors == 0 && smooth_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/nmsf_pkg.sv
hw/rtl/nmsf_front.sv
hw/rtl/nmsf_queue.sv
hw/rtl/nmsf_back.sv
hw/rtl/neighbour_mean_smoothing_filter.sv
tb/neighbour_mean_smoothing_filter_test.sv
